// ===== rtl/time_triggered_task_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Time-triggered task scheduler assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef TIME_TRIGGERED_TASK_SCHEDULER_MACROS_SVH
`define TIME_TRIGGERED_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tts assertion failed");

// Next-cycle implication, disabled while reset is held.
`define TTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tts assertion failed");

`endif

// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// Time-triggered task scheduler package
// Sizes, codes and shared types of the scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  // Number of task slots in the table (1 to 8, to fit the result's slot field).
  localparam int TASK_SLOTS   = 8;
  localparam int SLOT_W       = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  // Most run results a single dispatch pass may give.
  localparam int RESULT_CAP   = 8;
  localparam int CNT_W        = $clog2(RESULT_CAP);
  // Width of the slot field in a result.
  localparam int SLOT_FIELD_W = 3;
  localparam int TIME_W       = 16;
  localparam int PEND_W       = 8;
  // Command queue depth between the front and back ends.
  localparam int CMD_DEPTH    = 2;
  localparam int CMD_PTR_W    = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W    = $clog2(CMD_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_TICK = 2'd1,
    ACT_DISP = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  typedef struct packed {
    action_e             action;
    logic [TIME_W-1:0]   start_delay;
    logic [TIME_W-1:0]   repeat_period;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    kind_e                   kind;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    add_failed;
    logic                    last;
  } res_t;

  // Low bits of a slot index as carried in the result's slot field.
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_FIELD_W-1:0];
  endfunction

endpackage

// ===== rtl/tts_front.sv =====
// ----------------------------------------------------------------------------
// Scheduler front end
// Takes input beats, decodes the action and queues the meaningful ones.
// ----------------------------------------------------------------------------
module tts_front import tts_pkg::*; (
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*TIME_W-1:0]   s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  input  logic                  q_full_i,
  output push_t                 push_o
);

  logic    beat;
  action_e action;

  assign s_axis_tready = !q_full_i;
  assign beat          = s_axis_tvalid && s_axis_tready;
  assign action        = action_e'(s_axis_tuser);

  // An unknown action is taken off the bus but never queued.
  always_comb begin
    push_o.valid             = beat && (action inside {ACT_ADD, ACT_TICK, ACT_DISP});
    push_o.cmd.action        = action;
    push_o.cmd.start_delay   = s_axis_tdata[TIME_W-1:0];
    push_o.cmd.repeat_period = s_axis_tdata[2*TIME_W-1:TIME_W];
  end

endmodule

// ===== rtl/tts_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Scheduler command queue
// Short first-in first-out queue of decoded commands.
// ----------------------------------------------------------------------------
module tts_cmd_fifo import tts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  output logic  valid_o,
  output cmd_t  cmd_o,
  input  logic  pop_i
);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CMD_CNT_W'(CMD_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

// ===== rtl/tts_back.sv =====
// ----------------------------------------------------------------------------
// Scheduler back end
// Holds the task table, walks it one slot per cycle for ticks and, bar output
// stalls, dispatch passes, and presents results through an output register.
// ----------------------------------------------------------------------------
module tts_back import tts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic res_valid_o,
  output res_t res_o,
  input  logic res_ready_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TICK = 3'b010,
    ST_DISP = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;

  logic [TASK_SLOTS-1:0] used_q, used_d;
  logic [TASK_SLOTS-1:0] spent_q, spent_d;
  logic [TIME_W-1:0]     delay_q  [TASK_SLOTS];
  logic [TIME_W-1:0]     delay_d  [TASK_SLOTS];
  logic [TIME_W-1:0]     period_q [TASK_SLOTS];
  logic [TIME_W-1:0]     period_d [TASK_SLOTS];
  logic [PEND_W-1:0]     pend_q   [TASK_SLOTS];
  logic [PEND_W-1:0]     pend_d   [TASK_SLOTS];

  logic [TASK_SLOTS-1:0] pend_nz;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;
  logic                  more_after;
  logic                  out_free;
  logic                  last_idx;
  logic                  run_last;

  assign out_free    = !out_valid_q || res_ready_i;
  assign last_idx    = (idx_q == SLOT_W'(TASK_SLOTS - 1));
  assign run_last    = (cnt_q == CNT_W'(RESULT_CAP - 1)) || !more_after;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // Per-slot flags and the lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    more_after = 1'b0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      pend_nz[i] = |pend_q[i];
    end
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (SLOT_W'(i) > idx_q) begin
        more_after = more_after | pend_nz[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    used_d      = used_q;
    spent_d     = spent_q;
    delay_d     = delay_q;
    period_d    = period_q;
    pend_d      = pend_q;
    cmd_pop_o   = 1'b0;

    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.action)
            ACT_ADD: begin
              out_valid_d      = 1'b1;
              out_d.kind       = KIND_ADD;
              out_d.slot       = free_found ? slot_field(free_idx) : '0;
              out_d.add_failed = !free_found;
              out_d.last       = 1'b1;
              if (free_found) begin
                used_d[free_idx]   = 1'b1;
                spent_d[free_idx]  = 1'b0;
                delay_d[free_idx]  = cmd_i.start_delay;
                period_d[free_idx] = cmd_i.repeat_period;
                pend_d[free_idx]   = '0;
              end
            end
            ACT_TICK: begin
              state_d = ST_TICK;
              idx_d   = '0;
            end
            ACT_DISP: begin
              if (|pend_nz) begin
                state_d = ST_DISP;
                idx_d   = '0;
                cnt_d   = '0;
              end else begin
                out_valid_d      = 1'b1;
                out_d.kind       = KIND_NONE;
                out_d.slot       = '0;
                out_d.add_failed = 1'b0;
                out_d.last       = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_TICK: begin
        if (used_q[idx_q]) begin
          if (delay_q[idx_q] != '0) begin
            delay_d[idx_q] = delay_q[idx_q] - 1'b1;
          end else if (period_q[idx_q] != '0) begin
            if (pend_q[idx_q] != '1) begin
              pend_d[idx_q] = pend_q[idx_q] + 1'b1;
            end
            delay_d[idx_q] = period_q[idx_q] - 1'b1;
          end else if (!spent_q[idx_q]) begin
            if (pend_q[idx_q] != '1) begin
              pend_d[idx_q] = pend_q[idx_q] + 1'b1;
            end
            spent_d[idx_q] = 1'b1;
          end
        end
        if (last_idx) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_DISP: begin
        if (pend_nz[idx_q]) begin
          if (out_free) begin
            out_valid_d      = 1'b1;
            out_d.kind       = KIND_RUN;
            out_d.slot       = slot_field(idx_q);
            out_d.add_failed = 1'b0;
            out_d.last       = run_last;
            pend_d[idx_q]    = pend_q[idx_q] - 1'b1;
            // A spent one-shot whose final run goes out gives its slot back.
            if (used_q[idx_q] && (period_q[idx_q] == '0) && spent_q[idx_q] &&
                (pend_q[idx_q] == PEND_W'(1))) begin
              used_d[idx_q]  = 1'b0;
              spent_d[idx_q] = 1'b0;
              delay_d[idx_q] = '0;
            end
            cnt_d = cnt_q + 1'b1;
            if (run_last || last_idx) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
        end else if (last_idx) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      spent_q     <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        delay_q[i]  <= '0;
        period_q[i] <= '0;
        pend_q[i]   <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      spent_q     <= spent_d;
      delay_q     <= delay_d;
      period_q    <= period_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end

endmodule

// ===== rtl/time_triggered_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// Time-triggered task scheduler
// Cooperative scheduler over a table of task slots: adds tasks, counts ticks
// and hands out due runs in slot order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata (low bit up)                   tuser      tlast
//  s_axis    in         start_delay[15:0], repeat_period     action     -
//  m_axis    out        slot[2:0], add_failed, zero pad      kind       last of item
//
// An add is answered straight from the idle state, as is the nothing-due
// answer. A tick first takes the command, then visits each slot of the table
// in turn. A dispatch pass takes the command and then walks the slots up to
// the slot of its final run, held up by any output stalls.
// Reset clears the whole table, the command queue and the output register.
// A stalled output keeps the back end from taking a new command or giving the
// next run, though a tick walk runs on; the command queue keeps taking input
// beats until it is full.
//
module time_triggered_task_scheduler import tts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input item stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: start_delay [15:0], repeat_period [31:16]
  input  logic [2*TIME_W-1:0] s_axis_tdata,
  // tuser: action [1:0]
  input  logic [1:0]          s_axis_tuser,
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: slot [2:0], add_failed [3], zero [7:4]
  output logic [7:0]          m_axis_tdata,
  // tuser: kind [1:0]
  output logic [1:0]          m_axis_tuser,
  // tlast: final result of the input item
  output logic                m_axis_tlast
);

  push_t push;
  logic  q_full;
  logic  q_valid;
  cmd_t  q_cmd;
  logic  q_pop;
  res_t  res;

  // Front end: takes beats and drops the meaningless action code.
  tts_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push)
  );

  // Queue that lets the front end run ahead of a busy back end.
  tts_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  // Back end: task table, slot walker and result register.
  tts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  // Result fields packed onto the bus; the upper nibble of tdata is padding.
  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {4'b0000, res.add_failed, res.slot};
  assign m_axis_tlast = res.last;

endmodule

// ===== rtl/tts_checker.sv =====
// ----------------------------------------------------------------------------
// Time-triggered task scheduler checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "time_triggered_task_scheduler_macros.svh"

module tts_checker import tts_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A waiting result must not change or vanish.
  `TTS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // An add answer and a nothing-due answer each stand alone.
  `TTS_ASSERT_IMP(a_single_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == KIND_ADD || m_axis_tuser == KIND_NONE), m_axis_tlast)

  // A failed add is an add answer naming slot zero.
  `TTS_ASSERT_IMP(a_fail_form, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[3], m_axis_tuser == KIND_ADD && m_axis_tdata[2:0] == 3'd0)

  // Nothing-due carries an empty payload, padding included.
  `TTS_ASSERT_IMP(a_none_form, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == KIND_NONE, m_axis_tdata == 8'd0)

endmodule

bind time_triggered_task_scheduler tts_checker u_tts_checker (.*);
